// File: hw/rtl/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
`default_nettype none
package mtep_pkg;

	localparam int MTEP_MAX_VLQ_BYTES = 4;

	// Result kinds.
	localparam logic [4:0] KIND_PITCHWHEEL = 5'd6;
	localparam logic [4:0] KIND_SEQNUM     = 5'd7;
	localparam logic [4:0] KIND_TEXT       = 5'd8;
	localparam logic [4:0] KIND_CHANPREFIX = 5'd9;
	localparam logic [4:0] KIND_PORT       = 5'd10;
	localparam logic [4:0] KIND_EOT        = 5'd11;
	localparam logic [4:0] KIND_TEMPO      = 5'd12;
	localparam logic [4:0] KIND_SMPTE      = 5'd13;
	localparam logic [4:0] KIND_TIMESIG    = 5'd14;
	localparam logic [4:0] KIND_KEYSIG     = 5'd15;
	localparam logic [4:0] KIND_SEQUENCER  = 5'd16;
	localparam logic [4:0] KIND_PAYLOAD    = 5'd17;
	localparam logic [4:0] KIND_BAD_META   = 5'd18;
	localparam logic [4:0] KIND_NO_STATUS  = 5'd19;
	localparam logic [4:0] KIND_NONE       = 5'd0;

	// Byte values with a fixed meaning in a track.
	localparam logic [7:0] BYTE_META      = 8'hff;
	localparam logic [7:0] BYTE_SYSEX     = 8'hf0;
	localparam logic [7:0] BYTE_ESCAPE    = 8'hf7;
	localparam logic [7:0] META_SEQUENCER = 8'h7f;
	localparam logic [7:0] META_TEXT_LO   = 8'h01;
	localparam logic [7:0] META_TEXT_HI   = 8'h09;

	localparam logic [2:0] STATUS_PROGRAM  = 3'd4;
	localparam logic [2:0] STATUS_CHANPRES = 3'd5;
	localparam logic [2:0] STATUS_PITCH    = 3'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
	} item_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [27:0] delta_ticks;
		logic [3:0]  channel;
		logic [7:0]  first_value;
		logic [7:0]  second_value;
		logic [13:0] bend;
		logic [39:0] meta_value;
		logic [27:0] payload_length;
		logic        last_of_event;
	} result_t;

	// Kind of a fixed-form meta type, or KIND_NONE when it is not one.
	function automatic logic [4:0] fixed_kind(input logic [7:0] t);
		logic [4:0] k;
		case (t)
			8'h00: k = KIND_SEQNUM;
			8'h20: k = KIND_CHANPREFIX;
			8'h21: k = KIND_PORT;
			8'h2f: k = KIND_EOT;
			8'h51: k = KIND_TEMPO;
			8'h54: k = KIND_SMPTE;
			8'h58: k = KIND_TIMESIG;
			8'h59: k = KIND_KEYSIG;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mtep_parser.sv
// Parser state registers and the one-byte state update with its result.
`default_nettype none
module mtep_parser #(
	parameter int MAX_VLQ_BYTES = mtep_pkg::MTEP_MAX_VLQ_BYTES
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               fire,
	input  mtep_pkg::item_t   item,
	input  wire               pass_payload,
	output logic              res_valid,
	output mtep_pkg::result_t res
);
	import mtep_pkg::*;

	localparam int CntW = $clog2(MAX_VLQ_BYTES + 1);

	localparam logic [3:0] PH_DELTA     = 4'd0;
	localparam logic [3:0] PH_STATUS    = 4'd1;
	localparam logic [3:0] PH_DATA1     = 4'd2;
	localparam logic [3:0] PH_DATA2     = 4'd3;
	localparam logic [3:0] PH_META_TYPE = 4'd4;
	localparam logic [3:0] PH_META_LEN  = 4'd5;
	localparam logic [3:0] PH_META_BODY = 4'd6;
	localparam logic [3:0] PH_PAYLOAD   = 4'd7;
	localparam logic [3:0] PH_SYSEX_LEN = 4'd8;
	localparam logic [3:0] PH_SKIP      = 4'd9;
	localparam logic [3:0] PH_IDLE      = 4'd10;

	logic [3:0]      phase_q, phase_d;
	logic [27:0]     acc_q, acc_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [27:0]     dt_q, dt_d;
	logic [2:0]      rs_q, rs_d;
	logic            rsv_q, rsv_d;
	logic [3:0]      chan_q, chan_d;
	logic [7:0]      first_q, first_d;
	logic [7:0]      mtype_q, mtype_d;
	logic [27:0]     rem_q, rem_d;
	logic [39:0]     cap_q, cap_d;
	logic [27:0]     hlen_q, hlen_d;

	logic [7:0]      b;
	logic [3:0]      phase_e;
	logic [27:0]     acc_e, acc_new, rem_dec;
	logic [CntW-1:0] cnt_e, cnt_new;
	logic            vlq_done;
	logic [39:0]     cap_new;
	logic [4:0]      fk;
	logic            is_text;

	assign b       = item.data_byte;
	// A track start restarts the parse at the delta time of this very byte.
	assign phase_e = item.track_start ? PH_DELTA : phase_q;
	assign acc_e   = item.track_start ? '0 : acc_q;
	assign cnt_e   = item.track_start ? '0 : cnt_q;
	assign acc_new = {acc_e[20:0], b[6:0]};
	assign cnt_new = cnt_e + 1'b1;
	assign vlq_done = !b[7] || (cnt_new >= CntW'(MAX_VLQ_BYTES));
	assign rem_dec = rem_q - 28'd1;
	assign cap_new = {cap_q[31:0], b};
	assign fk      = fixed_kind(mtype_q);
	assign is_text = ((mtype_q >= META_TEXT_LO) && (mtype_q <= META_TEXT_HI))
		|| (mtype_q == META_SEQUENCER);

	always_comb begin
		phase_d   = phase_e;
		acc_d     = acc_e;
		cnt_d     = cnt_e;
		dt_d      = dt_q;
		rs_d      = rs_q;
		rsv_d     = item.track_start ? 1'b0 : rsv_q;
		chan_d    = chan_q;
		first_d   = first_q;
		mtype_d   = mtype_q;
		rem_d     = rem_q;
		cap_d     = cap_q;
		hlen_d    = hlen_q;
		res_valid = 1'b0;
		res       = '0;
		res.delta_ticks = dt_q;

		case (phase_e)
			PH_IDLE: begin
			end
			PH_DELTA: begin
				if (vlq_done) begin
					dt_d    = acc_new;
					acc_d   = '0;
					cnt_d   = '0;
					phase_d = PH_STATUS;
				end else begin
					acc_d = acc_new;
					cnt_d = cnt_new;
				end
			end
			PH_STATUS: begin
				if (b == BYTE_META) begin
					rsv_d   = 1'b0;
					phase_d = PH_META_TYPE;
				end else if (b == BYTE_SYSEX || b == BYTE_ESCAPE) begin
					rsv_d   = 1'b0;
					phase_d = PH_SYSEX_LEN;
				end else if (b[7:4] == 4'hf) begin
					rsv_d   = 1'b0;
					phase_d = PH_DELTA;
				end else if (b[7]) begin
					rs_d    = b[6:4];
					chan_d  = b[3:0];
					rsv_d   = 1'b1;
					phase_d = PH_DATA1;
				end else if (rsv_d) begin
					first_d = b;
					if (rs_q == STATUS_PROGRAM || rs_q == STATUS_CHANPRES) begin
						res_valid         = 1'b1;
						res.kind          = {2'b00, rs_q};
						res.channel       = chan_q;
						res.first_value   = b;
						res.last_of_event = 1'b1;
						phase_d           = PH_DELTA;
					end else begin
						phase_d = PH_DATA2;
					end
				end else begin
					res_valid         = 1'b1;
					res.kind          = KIND_NO_STATUS;
					res.first_value   = b;
					res.last_of_event = 1'b1;
					phase_d           = PH_DELTA;
				end
			end
			PH_DATA1: begin
				first_d = b;
				if (rs_q == STATUS_PROGRAM || rs_q == STATUS_CHANPRES) begin
					res_valid         = 1'b1;
					res.kind          = {2'b00, rs_q};
					res.channel       = chan_q;
					res.first_value   = b;
					res.last_of_event = 1'b1;
					phase_d           = PH_DELTA;
				end else begin
					phase_d = PH_DATA2;
				end
			end
			PH_DATA2: begin
				res_valid         = 1'b1;
				res.channel       = chan_q;
				res.last_of_event = 1'b1;
				if (rs_q == STATUS_PITCH) begin
					res.kind = KIND_PITCHWHEEL;
					res.bend = {b[6:0], first_q[6:0]};
				end else begin
					res.kind         = {2'b00, rs_q};
					res.first_value  = first_q;
					res.second_value = b;
				end
				phase_d = PH_DELTA;
			end
			PH_META_TYPE: begin
				mtype_d = b;
				phase_d = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (vlq_done) begin
					acc_d  = '0;
					cnt_d  = '0;
					hlen_d = acc_new;
					rem_d  = acc_new;
					cap_d  = '0;
					if (fk != KIND_NONE) begin
						if (acc_new == '0) begin
							res_valid         = 1'b1;
							res.kind          = fk;
							res.last_of_event = 1'b1;
							phase_d = (fk == KIND_EOT) ? PH_IDLE : PH_DELTA;
						end else begin
							phase_d = PH_META_BODY;
						end
					end else if (is_text) begin
						res_valid          = 1'b1;
						res.kind           = (mtype_q == META_SEQUENCER) ?
							KIND_SEQUENCER : KIND_TEXT;
						res.first_value    = mtype_q;
						res.payload_length = acc_new;
						res.last_of_event  = (acc_new == '0) || !pass_payload;
						phase_d = (acc_new != '0) ? PH_PAYLOAD : PH_DELTA;
					end else begin
						res_valid          = 1'b1;
						res.kind           = KIND_BAD_META;
						res.first_value    = mtype_q;
						res.payload_length = acc_new;
						res.last_of_event  = 1'b1;
						phase_d = (acc_new != '0) ? PH_SKIP : PH_DELTA;
					end
				end else begin
					acc_d = acc_new;
					cnt_d = cnt_new;
				end
			end
			PH_META_BODY: begin
				cap_d = cap_new;
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					res_valid         = 1'b1;
					res.kind          = fk;
					res.meta_value    = cap_new;
					res.last_of_event = 1'b1;
					phase_d = (fk == KIND_EOT) ? PH_IDLE : PH_DELTA;
				end
			end
			PH_PAYLOAD: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_DELTA;
				end
				if (pass_payload) begin
					res_valid          = 1'b1;
					res.kind           = KIND_PAYLOAD;
					res.first_value    = mtype_q;
					res.second_value   = b;
					res.payload_length = hlen_q;
					res.last_of_event  = (rem_dec == '0);
				end
			end
			PH_SYSEX_LEN: begin
				if (vlq_done) begin
					acc_d   = '0;
					cnt_d   = '0;
					rem_d   = acc_new;
					phase_d = (acc_new != '0) ? PH_SKIP : PH_DELTA;
				end else begin
					acc_d = acc_new;
					cnt_d = cnt_new;
				end
			end
			PH_SKIP: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_DELTA;
				end
			end
			default: begin
				phase_d = PH_DELTA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			acc_q   <= '0;
			cnt_q   <= '0;
			dt_q    <= '0;
			rs_q    <= '0;
			rsv_q   <= 1'b0;
			chan_q  <= '0;
			first_q <= '0;
			mtype_q <= '0;
			rem_q   <= '0;
			cap_q   <= '0;
			hlen_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			dt_q    <= dt_d;
			rs_q    <= rs_d;
			rsv_q   <= rsv_d;
			chan_q  <= chan_d;
			first_q <= first_d;
			mtype_q <= mtype_d;
			rem_q   <= rem_d;
			cap_q   <= cap_d;
			hlen_q  <= hlen_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: byte input, event output, configuration.
`default_nettype none
// The parser takes one track byte per cycle while its input is not stalled, and
// returns at most one decoded event per byte. A byte accepted into the input
// register is parsed once the result register is free or being drained, and its
// result lands in that register; a stall on the output holds the byte in between.
// The parse is the single parser state update between the input register and
// the result register. There is no clearing pass after reset: the parser is ready
// at once, and the configuration port is always ready. Write pass_payload only
// while no byte is in flight.
module midi_track_event_parser #(
	parameter int MAX_VLQ_BYTES = mtep_pkg::MTEP_MAX_VLQ_BYTES
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_stall,
	input  mtep_pkg::item_t   item,
	output logic              evt_valid,
	input  wire               evt_stall,
	output mtep_pkg::result_t evt,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire               cfg_data
);
	import mtep_pkg::*;

	logic    s1_valid_q;
	item_t   item_s1;
	logic    pass_payload_q;
	logic    evt_valid_q;
	result_t evt_q;
	logic    fire;
	logic    res_valid;
	result_t res;

	// The held byte is parsed when the output register is empty or is being
	// drained in this cycle. A byte that causes no result still waits for that,
	// which keeps the order of transfers simple.
	assign fire       = s1_valid_q && (!evt_valid_q || !evt_stall);
	assign item_stall = s1_valid_q && !fire;
	assign cfg_ready  = 1'b1;
	assign evt_valid  = evt_valid_q;
	assign evt        = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_payload_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			pass_payload_q <= cfg_data;
		end
	end

	// Input register: it takes a new byte whenever the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!item_stall) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	mtep_parser #(
		.MAX_VLQ_BYTES(MAX_VLQ_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.pass_payload(pass_payload_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register: a parse that yields nothing still frees the slot, since
	// a parse only happens once the old result has been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (fire) begin
			evt_valid_q <= res_valid;
		end else if (!evt_stall) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			evt_q <= res;
		end
	end

	// A stalled result must never be overwritten by a new parse.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid_q && evt_stall) |-> !fire)
		else $error("parse fired while a stalled result was held");

	// A byte held back by a stall is still held at the next edge.
	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> s1_valid_q)
		else $error("stalled input byte was lost");

	// Payload bytes only come from a meta event with a nonzero length.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid_q && evt_q.kind == KIND_PAYLOAD) |-> (evt_q.payload_length != '0))
		else $error("payload byte with zero declared length");

	// Only channel messages carry a channel number.
	a_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid_q && evt_q.kind > KIND_PITCHWHEEL) |-> (evt_q.channel == '0))
		else $error("channel set on a non-channel event");

endmodule
`default_nettype wire

// File: tb/mtep_tb_pkg.sv
// Track byte codes that the testbench uses to build events and to predict their decoding.
package mtep_tb_pkg;

	// Meta event types with a fixed-form body.
	localparam logic [7:0] META_SEQNUM     = 8'h00;
	localparam logic [7:0] META_CHANPREFIX = 8'h20;
	localparam logic [7:0] META_PORT       = 8'h21;
	localparam logic [7:0] META_EOT        = 8'h2f;
	localparam logic [7:0] META_TEMPO      = 8'h51;
	localparam logic [7:0] META_SMPTE      = 8'h54;
	localparam logic [7:0] META_TIMESIG    = 8'h58;
	localparam logic [7:0] META_KEYSIG     = 8'h59;

	// A meta type that no decoder knows.
	localparam logic [7:0] META_UNASSIGNED = 8'h60;

	// System status bytes that the parser drops.
	localparam logic [7:0] SYS_FIRST = 8'hf1;
	localparam logic [7:0] SYS_LAST  = 8'hfe;

endpackage

// File: tb/midi_event_checker.sv
// Event checker: predicts the parser's events from accepted bytes and compares each result.
module midi_event_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	input  wire               item_stall,
	input  mtep_pkg::item_t   item,
	input  wire               evt_valid,
	input  wire               evt_stall,
	input  mtep_pkg::result_t evt,
	input  wire               cfg_valid,
	input  wire               cfg_ready,
	input  wire               cfg_data,
	output int                fail_count,
	output int                outstanding,
	output int                bytes_parsed,
	output int                events_checked,
	output logic [19:0]       kinds_seen
);
	import mtep_pkg::*;
	import mtep_tb_pkg::*;

	localparam int MAX_PRINTED = 40;

	typedef enum logic [3:0] {
		PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN,
		PH_META_BODY, PH_PAYLOAD, PH_SYSEX_LEN, PH_SKIP, PH_IDLE
	} parse_phase_e;

	parse_phase_e phase = PH_DELTA;
	logic [27:0] vlq_acc = '0;
	int          vlq_count = 0;
	logic [27:0] delta_held = '0;
	logic [2:0]  run_status = '0;
	logic        run_valid = 1'b0;
	logic [3:0]  run_chan = '0;
	logic [7:0]  first_held = '0;
	logic [7:0]  meta_byte = '0;
	logic [27:0] bytes_left = '0;
	logic [39:0] capture = '0;
	logic [27:0] declared_len = '0;
	logic        pass_payload = 1'b1;

	result_t     expected_events[$];
	int          mismatches = 0;
	int          parsed = 0;
	int          checked = 0;
	logic [19:0] seen = '0;

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [39:0] got,
			input logic [39:0] want);
		if (got !== want)
			report_mismatch($sformatf("event %0d field %s: got %0h, expected %0h",
				checked, name, got, want));
	endtask

	// Shifts one byte into the quantity; returns 1 when the quantity is complete.
	function automatic logic vlq_absorb(input logic [7:0] b);
		vlq_acc = {vlq_acc[20:0], b[6:0]};
		vlq_count++;
		if (!b[7] || vlq_count >= MTEP_MAX_VLQ_BYTES) begin
			vlq_count = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [4:0] meta_fixed_kind(input logic [7:0] t);
		case (t)
			META_SEQNUM:     return KIND_SEQNUM;
			META_CHANPREFIX: return KIND_CHANPREFIX;
			META_PORT:       return KIND_PORT;
			META_EOT:        return KIND_EOT;
			META_TEMPO:      return KIND_TEMPO;
			META_SMPTE:      return KIND_SMPTE;
			META_TIMESIG:    return KIND_TIMESIG;
			META_KEYSIG:     return KIND_KEYSIG;
			default:         return KIND_NONE;
		endcase
	endfunction

	task automatic emit(input logic [4:0] kind, input logic [3:0] chan,
			input logic [7:0] v1, input logic [7:0] v2, input logic [13:0] bend,
			input logic [39:0] mval, input logic [27:0] plen, input logic last);
		result_t r;
		r.kind           = kind;
		r.delta_ticks    = delta_held;
		r.channel        = chan;
		r.first_value    = v1;
		r.second_value   = v2;
		r.bend           = bend;
		r.meta_value     = mval;
		r.payload_length = plen;
		r.last_of_event  = last;
		expected_events.insert(expected_events.size(), r);
	endtask

	task automatic finish_fixed_meta();
		logic [4:0] k;
		k = meta_fixed_kind(meta_byte);
		emit(k, '0, '0, '0, '0, capture, '0, 1'b1);
		phase = (k == KIND_EOT) ? PH_IDLE : PH_DELTA;
	endtask

	task automatic take_first_data(input logic [7:0] b);
		first_held = b;
		if (run_status == STATUS_PROGRAM || run_status == STATUS_CHANPRES) begin
			emit({2'b00, run_status}, run_chan, b, '0, '0, '0, '0, 1'b1);
			phase = PH_DELTA;
		end else begin
			phase = PH_DATA2;
		end
	endtask

	task automatic decode_track_byte(input logic [7:0] b, input logic start);
		logic [27:0] len;
		if (start) begin
			phase = PH_DELTA;
			vlq_acc = '0;
			vlq_count = 0;
			run_valid = 1'b0;
		end
		case (phase)
			PH_IDLE: begin
			end
			PH_DELTA: begin
				if (vlq_absorb(b)) begin
					delta_held = vlq_acc;
					vlq_acc = '0;
					phase = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (b == BYTE_META) begin
					run_valid = 1'b0;
					phase = PH_META_TYPE;
				end else if (b == BYTE_SYSEX || b == BYTE_ESCAPE) begin
					run_valid = 1'b0;
					phase = PH_SYSEX_LEN;
				end else if (b >= BYTE_SYSEX) begin
					run_valid = 1'b0;
					phase = PH_DELTA;
				end else if (b[7]) begin
					run_status = b[6:4];
					run_chan = b[3:0];
					run_valid = 1'b1;
					phase = PH_DATA1;
				end else if (run_valid) begin
					take_first_data(b);
				end else begin
					emit(KIND_NO_STATUS, '0, b, '0, '0, '0, '0, 1'b1);
					phase = PH_DELTA;
				end
			end
			PH_DATA1: begin
				take_first_data(b);
			end
			PH_DATA2: begin
				if (run_status == STATUS_PITCH)
					emit(KIND_PITCHWHEEL, run_chan, '0, '0, {b[6:0], first_held[6:0]}, '0,
						'0, 1'b1);
				else
					emit({2'b00, run_status}, run_chan, first_held, b, '0, '0, '0, 1'b1);
				phase = PH_DELTA;
			end
			PH_META_TYPE: begin
				meta_byte = b;
				phase = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (vlq_absorb(b)) begin
					len = vlq_acc;
					vlq_acc = '0;
					declared_len = len;
					bytes_left = len;
					capture = '0;
					if (meta_fixed_kind(meta_byte) != KIND_NONE) begin
						if (len == 0)
							finish_fixed_meta();
						else
							phase = PH_META_BODY;
					end else if ((meta_byte >= META_TEXT_LO && meta_byte <= META_TEXT_HI) ||
							meta_byte == META_SEQUENCER) begin
						emit((meta_byte == META_SEQUENCER) ? KIND_SEQUENCER : KIND_TEXT, '0,
							meta_byte, '0, '0, '0, len, (len == 0) || !pass_payload);
						phase = (len != 0) ? PH_PAYLOAD : PH_DELTA;
					end else begin
						emit(KIND_BAD_META, '0, meta_byte, '0, '0, '0, len, 1'b1);
						phase = (len != 0) ? PH_SKIP : PH_DELTA;
					end
				end
			end
			PH_META_BODY: begin
				capture = {capture[31:0], b};
				bytes_left = bytes_left - 1'b1;
				if (bytes_left == 0)
					finish_fixed_meta();
			end
			PH_PAYLOAD: begin
				bytes_left = bytes_left - 1'b1;
				if (bytes_left == 0)
					phase = PH_DELTA;
				if (pass_payload)
					emit(KIND_PAYLOAD, '0, meta_byte, b, '0, '0, declared_len,
						bytes_left == 0);
			end
			PH_SYSEX_LEN: begin
				if (vlq_absorb(b)) begin
					bytes_left = vlq_acc;
					vlq_acc = '0;
					phase = (bytes_left != 0) ? PH_SKIP : PH_DELTA;
				end
			end
			PH_SKIP: begin
				bytes_left = bytes_left - 1'b1;
				if (bytes_left == 0)
					phase = PH_DELTA;
			end
			default: begin
				phase = PH_DELTA;
			end
		endcase
	endtask

	task automatic compare_event(input result_t got);
		result_t want;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected event of kind %0d", got.kind));
		end else begin
			want = expected_events.pop_front();
			seen[want.kind] = 1'b1;
			check_field("kind", 40'(got.kind), 40'(want.kind));
			check_field("delta_ticks", 40'(got.delta_ticks), 40'(want.delta_ticks));
			check_field("channel", 40'(got.channel), 40'(want.channel));
			check_field("first_value", 40'(got.first_value), 40'(want.first_value));
			check_field("second_value", 40'(got.second_value), 40'(want.second_value));
			check_field("bend", 40'(got.bend), 40'(want.bend));
			check_field("meta_value", got.meta_value, want.meta_value);
			check_field("payload_length", 40'(got.payload_length),
				40'(want.payload_length));
			check_field("last_of_event", 40'(got.last_of_event), 40'(want.last_of_event));
			checked++;
		end
	endtask

	// Transfers are sampled at the edge, so every value read here is the one
	// from before the edge, whatever order the processes run in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_DELTA;
			vlq_acc = '0;
			vlq_count = 0;
			delta_held = '0;
			run_status = '0;
			run_valid = 1'b0;
			run_chan = '0;
			first_held = '0;
			meta_byte = '0;
			bytes_left = '0;
			capture = '0;
			declared_len = '0;
			pass_payload = 1'b1;
			expected_events.delete();
			outstanding <= 0;
			fail_count <= 0;
			bytes_parsed <= 0;
			events_checked <= 0;
			kinds_seen <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				pass_payload = cfg_data;
			if (item_valid && !item_stall) begin
				decode_track_byte(item.data_byte, item.track_start);
				parsed++;
			end
			if (evt_valid && !evt_stall)
				compare_event(evt);
			outstanding <= expected_events.size();
			fail_count <= mismatches;
			bytes_parsed <= parsed;
			events_checked <= checked;
			kinds_seen <= seen;
		end
	end

endmodule

// File: tb/tb_midi_track_event_parser.sv
// Testbench top for the MIDI track event parser: byte stimulus, pacing and the verdict.
module tb_midi_track_event_parser;
	import mtep_pkg::*;
	import mtep_tb_pkg::*;

	// The run is about 1150 bytes; even with every gap and the long hold it
	// stays far below this limit, so this limit only catches a hang.
	localparam int CYCLE_LIMIT = 200000;
	// Length of the long receiver hold that backs the parser up.
	localparam int HOLD_CYCLES = 300;
	// A byte passes through the input and the result register; wait a bit more.
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	// Percentage of cycles in which each side idles while pacing is on.
	localparam int IDLE_PCT = 14;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    evt_valid;
	logic    evt_stall;
	result_t evt;
	logic    cfg_valid;
	logic    cfg_ready;
	logic    cfg_data;

	int          fail_count;
	int          outstanding;
	int          bytes_parsed;
	int          events_checked;
	logic [19:0] kinds_seen;

	// Pacing controls, set by the stimulus process.
	logic jitter_on = 1'b1;
	int   hold_asks = 0;
	int   holds_done = 0;

	// Set at the end of an event that leaves the parser stuck (end of track or
	// a length too large to finish), so the next byte restarts the track.
	logic       restart_next = 1'b0;
	logic [2:0] last_chan_kind = '0;
	int         bytes_sent = 0;
	int         cycles = 0;

	midi_track_event_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt        (evt),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	midi_event_checker event_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.evt_valid      (evt_valid),
		.evt_stall      (evt_stall),
		.evt            (evt),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.bytes_parsed   (bytes_parsed),
		.events_checked (events_checked),
		.kinds_seen     (kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run never gets close to this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d events still due", cycles, outstanding);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side. It stalls at random while pacing is on, and when the
	// stimulus asks for it, holds the output off for a long stretch that it
	// counts itself. The sender keeps offering bytes meanwhile, so the parser
	// fills and has to stall its input.
	initial begin
		evt_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < hold_asks) begin
				evt_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			evt_stall <= jitter_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// One byte transfer. Valid is only lowered in an idle gap, so a byte that
	// follows right after an accepted one never sees valid dropped and raised
	// in the same step. The payload holds still while the parser stalls.
	task automatic send_byte(input logic [7:0] b);
		logic ts;
		ts = restart_next;
		restart_next = 1'b0;
		if (jitter_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, track_start: ts};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Sends a quantity in exactly n bytes, most significant group first. With
	// open_end the last byte keeps its continuation bit, which the parser must
	// cut off at the byte limit.
	task automatic send_vlq(input logic [27:0] v, input int n, input logic open_end);
		logic [7:0] b;
		for (int i = n - 1; i >= 0; i--) begin
			b = {(i != 0) || open_end, 7'(v >> (7 * i))};
			send_byte(b);
		end
	endtask

	function automatic int vlq_size(input logic [27:0] v);
		int n;
		n = 1;
		while (n < MTEP_MAX_VLQ_BYTES && (v >> (7 * n)) != 0)
			n++;
		return n;
	endfunction

	// Mostly the shortest encoding; sometimes padded with empty leading groups,
	// and at full size sometimes left open at the end.
	task automatic send_quantity(input logic [27:0] v);
		int n;
		n = vlq_size(v);
		if ($urandom_range(9) == 0)
			n = $urandom_range(MTEP_MAX_VLQ_BYTES, n);
		send_vlq(v, n, (n == MTEP_MAX_VLQ_BYTES) && ($urandom_range(3) == 0));
	endtask

	function automatic logic [27:0] pick_delta();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return 28'($urandom_range(127));
			6, 7:             return 28'($urandom_range(16383));
			default:          return 28'($urandom);
		endcase
	endfunction

	function automatic logic [27:0] pick_length();
		case ($urandom_range(19))
			14, 15, 16, 17: return 28'($urandom_range(40, 7));
			18:             return 28'($urandom_range(200, 128));
			default:        return 28'($urandom_range(6));
		endcase
	endfunction

	// Data bytes mostly keep the top bit clear; a status byte in data position
	// must be taken as plain data.
	function automatic logic [7:0] pick_data();
		if ($urandom_range(9) == 0)
			return 8'($urandom);
		return 8'($urandom_range(127));
	endfunction

	function automatic logic is_defined_meta(input logic [7:0] t);
		case (t)
			META_SEQNUM, META_CHANPREFIX, META_PORT, META_EOT, META_TEMPO,
			META_SMPTE, META_TIMESIG, META_KEYSIG, META_SEQUENCER: return 1'b1;
			default: return (t >= META_TEXT_LO) && (t <= META_TEXT_HI);
		endcase
	endfunction

	function automatic logic [7:0] pick_fixed_meta();
		case ($urandom_range(6))
			0:       return META_SEQNUM;
			1:       return META_CHANPREFIX;
			2:       return META_PORT;
			3:       return META_TEMPO;
			4:       return META_SMPTE;
			5:       return META_TIMESIG;
			default: return META_KEYSIG;
		endcase
	endfunction

	function automatic logic [7:0] pick_unassigned_meta();
		logic [7:0] t;
		t = 8'($urandom);
		while (is_defined_meta(t))
			t = 8'($urandom);
		return t;
	endfunction

	// Length and body of a meta or sysex event. Now and then the declared
	// length is far too large to send; a few body bytes go out and the next
	// byte restarts the track to get the parser back.
	task automatic send_length_and_body(input logic [27:0] len);
		if ($urandom_range(49) == 0) begin
			send_quantity(28'($urandom) | 28'h100);
			repeat ($urandom_range(3))
				send_byte(8'($urandom));
			restart_next = 1'b1;
		end else begin
			send_quantity(len);
			repeat (len)
				send_byte(8'($urandom));
		end
	endtask

	// A channel message. A third of them lean on running status and leave the
	// status byte out; the byte count follows the last status that was sent.
	task automatic send_channel_msg();
		logic [2:0] kind;
		send_quantity(pick_delta());
		if ($urandom_range(2) == 0) begin
			kind = last_chan_kind;
		end else begin
			kind = 3'($urandom_range(6));
			last_chan_kind = kind;
			send_byte({1'b1, kind, 4'($urandom)});
		end
		send_byte(pick_data());
		if (kind != STATUS_PROGRAM && kind != STATUS_CHANPRES)
			send_byte(pick_data());
	endtask

	task automatic send_meta(input logic [7:0] t);
		send_quantity(pick_delta());
		send_byte(BYTE_META);
		send_byte(t);
		send_length_and_body(pick_length());
	endtask

	task automatic send_sysex();
		send_quantity(pick_delta());
		send_byte($urandom_range(1) ? BYTE_SYSEX : BYTE_ESCAPE);
		send_length_and_body(pick_length());
	endtask

	task automatic send_system_byte();
		logic [7:0] b;
		b = 8'($urandom_range(SYS_LAST, SYS_FIRST));
		while (b == BYTE_ESCAPE)
			b = 8'($urandom_range(SYS_LAST, SYS_FIRST));
		send_quantity(pick_delta());
		send_byte(b);
	endtask

	// End of track, a few bytes that the parser must ignore, then a new track.
	task automatic send_end_of_track();
		send_quantity(pick_delta());
		send_byte(BYTE_META);
		send_byte(META_EOT);
		send_length_and_body(($urandom_range(3) == 0) ? 28'($urandom_range(3, 1)) : '0);
		repeat ($urandom_range(3))
			send_byte(8'($urandom));
		restart_next = 1'b1;
	endtask

	// Mostly well-formed events with random content; the rest is stray bytes
	// that knock the parser off its framing.
	task automatic send_random_event();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			send_channel_msg();
		else if (pick < 58)
			send_meta(pick_fixed_meta());
		else if (pick < 70)
			send_meta(8'($urandom_range(META_TEXT_HI, META_TEXT_LO)));
		else if (pick < 75)
			send_meta(META_SEQUENCER);
		else if (pick < 80)
			send_meta(pick_unassigned_meta());
		else if (pick < 87)
			send_sysex();
		else if (pick < 90)
			send_system_byte();
		else if (pick < 93)
			send_end_of_track();
		else
			repeat ($urandom_range(3, 1))
				send_byte(8'($urandom));
	endtask

	task automatic send_random_until(input int target);
		while (bytes_sent < target)
			send_random_event();
	endtask

	// The register is only written with nothing in flight: input idle, every
	// predicted event delivered, and a settling wait for a byte that was
	// still being parsed without producing an event.
	task automatic write_pass_payload(input logic v);
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, payload passing at its reset value of one.
		// Program change on channel 5, starting a new track.
		restart_next = 1'b1;
		send_byte(8'h00);
		send_byte(8'hc5);
		send_byte(8'h7f);
		// Largest delta time, sent as four bytes that all carry the
		// continuation bit, then a pitch wheel on channel 15 whose data bytes
		// have the top bit set.
		send_vlq(28'h0fffffff, MTEP_MAX_VLQ_BYTES, 1'b1);
		send_byte(8'hef);
		send_byte(8'h80);
		send_byte(8'hff);
		// Sequence number with zero length.
		send_byte(8'h00);
		send_byte(BYTE_META);
		send_byte(META_SEQNUM);
		send_byte(8'h00);
		// Text event with an empty payload.
		send_byte(8'h00);
		send_byte(BYTE_META);
		send_byte(META_TEXT_LO);
		send_byte(8'h00);
		// Unknown meta type with zero length.
		send_byte(8'h00);
		send_byte(BYTE_META);
		send_byte(META_UNASSIGNED);
		send_byte(8'h00);
		// Data byte while meta has cancelled running status.
		send_byte(8'h00);
		send_byte(8'h40);
		// System status byte that is dropped.
		send_byte(8'h00);
		send_byte(SYS_FIRST);
		// End of track, then a byte that must be ignored.
		send_byte(8'h00);
		send_byte(BYTE_META);
		send_byte(META_EOT);
		send_byte(8'h00);
		send_byte(8'h55);
		restart_next = 1'b1;

		// Random part in four settings of payload passing.
		write_pass_payload(1'b0);
		send_random_until(400);

		// No idling on either side here, apart from one long receiver hold
		// while a burst of channel messages keeps coming.
		write_pass_payload(1'b1);
		jitter_on = 1'b0;
		hold_asks++;
		repeat (40) send_channel_msg();
		send_random_until(750);
		jitter_on = 1'b1;

		write_pass_payload(1'b0);
		send_random_until(950);
		write_pass_payload(1'b1);
		send_random_until(1140);

		// Drain: wait for every predicted event, then a little longer so that
		// any extra event would still be caught.
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d track bytes and %0d checked events, %0d of 20 event kinds.",
			bytes_parsed, events_checked, $countones(kinds_seen));
		$display("Payload passing went off and on twice; one receiver hold of %0d cycles.",
			HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
